// File: sv/subsampled_frame_luma_average_assert.svh
// assertion macros shared by the frame luma average modules
`ifndef SUBSAMPLED_FRAME_LUMA_AVERAGE_ASSERT_SVH
`define SUBSAMPLED_FRAME_LUMA_AVERAGE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SFLA_ASSERT_IMP(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define SFLA_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// File: sv/sfla_pkg.sv
// types, constants and helper functions of the frame luma average block
`default_nettype none

package sfla_pkg;

	localparam int MAX_DIMENSION = 8192;
	localparam int MAX_STRIDE    = 64;

	localparam int DIM_W    = 14;
	localparam int STEP_W   = 7;
	localparam int COLOR_W  = 8;
	localparam int OUT_W    = 16;
	localparam int POS_W    = $clog2(MAX_DIMENSION);
	localparam int PHASE_W  = $clog2(MAX_STRIDE);
	localparam int LUMA_W   = 24;
	localparam int SUM_W    = 50;
	localparam int COUNT_W  = 27;
	localparam int QUO_W    = OUT_W + 1;
	localparam int DEN_W    = COUNT_W + 8;
	localparam int REM_W    = SUM_W - QUO_W;
	localparam int STEP_CNT_W = $clog2(QUO_W);

	localparam logic [LUMA_W-1:0] WEIGHT_R = LUMA_W'(19595);
	localparam logic [LUMA_W-1:0] WEIGHT_G = LUMA_W'(38470);
	localparam logic [LUMA_W-1:0] WEIGHT_B = LUMA_W'(7471);

	typedef enum logic [1:0] {
		CFG_FRAME_WIDTH  = 2'd0,
		CFG_FRAME_HEIGHT = 2'd1,
		CFG_STEP_X       = 2'd2,
		CFG_STEP_Y       = 2'd3
	} cfg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_CHECK,
		ST_DIVIDE,
		ST_RESULT
	} ctrl_state_t;

	typedef struct packed {
		logic accept;
		logic load;
		logic prep;
		logic check;
		logic step;
	} dp_cmd_t;

	typedef struct packed {
		logic pix_last;
		logic end_s1;
	} dp_status_t;

	// last valid position for a dimension register, zero acts as one
	function automatic logic [POS_W-1:0] dim_last(input logic [DIM_W-1:0] v);
		logic [POS_W-1:0] r;
		if (v == '0) begin
			r = '0;
		end else if (v > DIM_W'(MAX_DIMENSION)) begin
			r = POS_W'(MAX_DIMENSION - 1);
		end else begin
			r = POS_W'(v - DIM_W'(1));
		end
		return r;
	endfunction

	function automatic logic [STEP_W-1:0] stride_clamp(input logic [STEP_W-1:0] v);
		logic [STEP_W-1:0] r;
		if (v == '0) begin
			r = STEP_W'(1);
		end else if (v > STEP_W'(MAX_STRIDE)) begin
			r = STEP_W'(MAX_STRIDE);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: sv/sfla_if.sv
// handshake channel interfaces for pixels, results and register writes
`default_nettype none

interface sfla_pixel_if import sfla_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COLOR_W-1:0] red;
	logic [COLOR_W-1:0] green;
	logic [COLOR_W-1:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface sfla_luma_if import sfla_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OUT_W-1:0] average_luma;

	modport source (output valid, output average_luma, input ready);
	modport sink (input valid, input average_luma, output ready);
endinterface

interface sfla_cfg_if import sfla_pkg::*; ();
	logic             valid;
	logic             ready;
	cfg_index_t       index;
	logic [DIM_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: sv/subsampled_frame_luma_average.sv
// Top level of the subsampled frame luma average.
// Throughput: one pixel item per cycle; the last pixel of a frame is held off while
// the previous frame's divide or result is still pending.
// The result becomes valid after the last pixel is accepted, following one luma stage,
// load, divisor setup, range check and a 17-step restoring divider.
// Reset: asynchronous active low; clears position, sums and control, loads register defaults.
`default_nettype none

module subsampled_frame_luma_average import sfla_pkg::*; (
	input wire           clk,
	input wire           arst_n,
	sfla_pixel_if.sink   pixel,
	sfla_luma_if.source  result,
	sfla_cfg_if.sink     cfg
);

	dp_cmd_t    cmd;
	dp_status_t status;
	logic       pixel_ready;
	logic       result_valid;

	assign pixel.ready  = pixel_ready;
	assign result.valid = result_valid;
	assign cfg.ready    = 1'b1;

	sfla_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel.valid),
		.pixel_ready  (pixel_ready),
		.result_valid (result_valid),
		.result_ready (result.ready),
		.status       (status),
		.cmd          (cmd)
	);

	sfla_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg.valid),
		.cfg_index    (cfg.index),
		.cfg_data     (cfg.data),
		.red          (pixel.red),
		.green        (pixel.green),
		.blue         (pixel.blue),
		.average_luma (result.average_luma),
		.cmd          (cmd),
		.status       (status)
	);

endmodule

`default_nettype wire

// File: sv/sfla_ctrl.sv
// controller: pixel flow control and end-of-frame divide sequencing
`default_nettype none
`include "subsampled_frame_luma_average_assert.svh"

module sfla_ctrl import sfla_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         pixel_valid,
	output logic        pixel_ready,
	output logic        result_valid,
	input  wire         result_ready,
	input  dp_status_t  status,
	output dp_cmd_t     cmd
);

	ctrl_state_t             state_q;
	ctrl_state_t             state_next;
	logic [STEP_CNT_W-1:0]   step_cnt_q;
	logic                    step_last;

	assign step_last = (step_cnt_q == STEP_CNT_W'(QUO_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_cnt_q <= '0;
		end else begin
			state_q <= state_next;
			if (state_q == ST_CHECK) begin
				step_cnt_q <= '0;
			end else if (state_q == ST_DIVIDE) begin
				step_cnt_q <= step_cnt_q + STEP_CNT_W'(1);
			end
		end
	end

	always_comb begin
		state_next   = state_q;
		cmd          = '0;
		result_valid = 1'b0;
		// a frame-ending item waits until the divider is free
		pixel_ready  = !(status.pix_last && (state_q != ST_IDLE || status.end_s1));
		cmd.accept   = pixel_valid && pixel_ready;
		case (state_q)
			ST_IDLE: begin
				if (status.end_s1) begin
					cmd.load   = 1'b1;
					state_next = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep   = 1'b1;
				state_next = ST_CHECK;
			end
			ST_CHECK: begin
				cmd.check  = 1'b1;
				state_next = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				cmd.step = 1'b1;
				if (step_last) begin
					state_next = ST_RESULT;
				end
			end
			ST_RESULT: begin
				result_valid = 1'b1;
				if (result_ready) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	`SFLA_ASSERT_IMP(a_start_when_idle, status.end_s1, state_q == ST_IDLE, "frame end while divider busy")
	`SFLA_ASSERT_NEXT(a_divide_length, (state_q == ST_DIVIDE) && step_last, state_q == ST_RESULT, "divide did not finish")

endmodule

`default_nettype wire

// File: sv/sfla_datapath.sv
// datapath: raster tracking, luma accumulation, registers and restoring divider
`default_nettype none
`include "subsampled_frame_luma_average_assert.svh"

module sfla_datapath import sfla_pkg::*; (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cfg_valid,
	input  cfg_index_t         cfg_index,
	input  wire  [DIM_W-1:0]   cfg_data,
	input  wire  [COLOR_W-1:0] red,
	input  wire  [COLOR_W-1:0] green,
	input  wire  [COLOR_W-1:0] blue,
	output logic [OUT_W-1:0]   average_luma,
	input  dp_cmd_t            cmd,
	output dp_status_t         status
);

	logic [DIM_W-1:0]   frame_width_q;
	logic [DIM_W-1:0]   frame_height_q;
	logic [STEP_W-1:0]  step_x_q;
	logic [STEP_W-1:0]  step_y_q;

	logic [POS_W-1:0]   col_q;
	logic [POS_W-1:0]   row_q;
	logic [PHASE_W-1:0] col_phase_q;
	logic [PHASE_W-1:0] row_phase_q;

	logic [LUMA_W-1:0]  luma_s1;
	logic               sample_s1;
	logic               end_s1;

	logic [SUM_W-1:0]   sum_q;
	logic [COUNT_W-1:0] count_q;
	logic [SUM_W-1:0]   sum_next;
	logic [COUNT_W-1:0] count_next;

	logic [DEN_W-1:0]   rem_q;
	logic [QUO_W-1:0]   num_q;
	logic [QUO_W-1:0]   quo_q;
	logic [DEN_W-1:0]   den_q;
	logic [COUNT_W-1:0] count_snap_q;
	logic               sat_q;
	logic               zero_q;

	logic [POS_W-1:0]   w_last;
	logic [POS_W-1:0]   h_last;
	logic [STEP_W-1:0]  sx;
	logic [STEP_W-1:0]  sy;
	logic               col_end;
	logic               row_end;
	logic [STEP_W-1:0]  col_phase_inc;
	logic [STEP_W-1:0]  row_phase_inc;
	logic [LUMA_W-1:0]  luma;
	logic [DEN_W:0]     shifted;
	logic [DEN_W:0]     diff;
	logic               ge;

	assign w_last  = dim_last(frame_width_q);
	assign h_last  = dim_last(frame_height_q);
	assign sx      = stride_clamp(step_x_q);
	assign sy      = stride_clamp(step_y_q);
	assign col_end = (col_q >= w_last);
	assign row_end = (row_q >= h_last);

	assign col_phase_inc = {1'b0, col_phase_q} + STEP_W'(1);
	assign row_phase_inc = {1'b0, row_phase_q} + STEP_W'(1);

	assign luma = WEIGHT_R * LUMA_W'(red) + WEIGHT_G * LUMA_W'(green)
		+ WEIGHT_B * LUMA_W'(blue);

	assign status.pix_last = col_end && row_end;
	assign status.end_s1   = end_s1;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= DIM_W'(1920);
			frame_height_q <= DIM_W'(1080);
			step_x_q       <= STEP_W'(8);
			step_y_q       <= STEP_W'(8);
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				CFG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				CFG_STEP_X:       step_x_q       <= cfg_data[STEP_W-1:0];
				CFG_STEP_Y:       step_y_q       <= cfg_data[STEP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// raster position and sampling phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			col_phase_q <= '0;
			row_phase_q <= '0;
			sample_s1   <= 1'b0;
			end_s1      <= 1'b0;
		end else begin
			sample_s1 <= cmd.accept && (col_phase_q == '0) && (row_phase_q == '0);
			end_s1    <= cmd.accept && col_end && row_end;
			if (cmd.accept) begin
				if (col_end) begin
					col_q       <= '0;
					col_phase_q <= '0;
					if (row_end) begin
						row_q       <= '0;
						row_phase_q <= '0;
					end else begin
						row_q       <= row_q + POS_W'(1);
						row_phase_q <= (row_phase_inc >= sy) ? '0 : row_phase_inc[PHASE_W-1:0];
					end
				end else begin
					col_q       <= col_q + POS_W'(1);
					col_phase_q <= (col_phase_inc >= sx) ? '0 : col_phase_inc[PHASE_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		luma_s1 <= luma;
	end

	assign sum_next   = sum_q + (sample_s1 ? SUM_W'(luma_s1) : '0);
	assign count_next = count_q + COUNT_W'(sample_s1);

	// accumulator, handed to the divider and cleared at frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
		end else if (cmd.load) begin
			sum_q   <= '0;
			count_q <= '0;
		end else begin
			sum_q   <= sum_next;
			count_q <= count_next;
		end
	end

	assign shifted = {rem_q, num_q[QUO_W-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign ge      = (shifted >= {1'b0, den_q});

	// restoring divider, one quotient bit per step
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q        <= DEN_W'(sum_next[SUM_W-1:QUO_W]);
			num_q        <= sum_next[QUO_W-1:0];
			count_snap_q <= count_next;
		end
		if (cmd.prep) begin
			den_q  <= {count_snap_q, 8'h00} - DEN_W'(count_snap_q);
			zero_q <= (count_snap_q == '0);
		end
		if (cmd.check) begin
			// high part already holds the divisor: quotient beyond range
			sat_q <= (DEN_W'(rem_q) >= den_q);
		end
		if (cmd.step) begin
			rem_q <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
			num_q <= {num_q[QUO_W-2:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign average_luma = zero_q ? '0 :
		((sat_q || quo_q[QUO_W-1]) ? {OUT_W{1'b1}} : quo_q[OUT_W-1:0]);

	`SFLA_ASSERT_NEXT(a_clear_on_load, cmd.load, (sum_q == '0) && (count_q == '0), "accumulator not cleared")
	`SFLA_ASSERT_NEXT(a_frame_end_flag, cmd.accept && col_end && row_end, end_s1, "frame end lost")

endmodule

`default_nettype wire
